FILE: sv/dnpr_pkg.sv
// Package for the DNP3 object record parser: payload structs, codes,
// layout lookup functions and the result burst descriptor. No dependencies.
package dnpr_pkg;

  typedef enum logic [1:0] {
    KIND_HDR  = 2'd0,
    KIND_DATA = 2'd1,
    KIND_END  = 2'd2,
    KIND_RSVD = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OBJ       = 2'd0,
    ST_DONE      = 2'd1,
    ST_UNKNOWN   = 2'd2,
    ST_MALFORMED = 2'd3
  } status_e;

  localparam logic [3:0] LAY_BITS = 4'd0;
  localparam logic [3:0] LAY_FLAG = 4'd1;
  localparam logic [3:0] LAY_CROB = 4'd3;
  localparam logic [4:0] MAP_NODATA  = 5'h1e;
  localparam logic [4:0] MAP_UNKNOWN = 5'h1f;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  group;
    logic [7:0]  variation;
    logic [2:0]  pfx_sel;
    logic [31:0] start_index;
    logic [31:0] object_count;
    logic [7:0]  data_byte;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  layout;
    logic [31:0] point_index;
    logic [31:0] prefix_value;
    logic [7:0]  flags;
    logic [31:0] value;
    logic [31:0] off_dur;
    logic [47:0] timestamp;
    logic [7:0]  control_count;
    logic [7:0]  status_byte;
    logic        last;
  } out_t;

  // One transaction's worth of results: n_obj objects, then an optional tail.
  typedef struct packed {
    logic        is_bits;
    logic [3:0]  n_obj;
    logic        tail;
    status_e     tail_status;
    logic [3:0]  layout;
    logic        use_prefix;
    logic [31:0] point_base;
    logic [31:0] prefix;
    logic [7:0]  flags;
    logic [31:0] value;
    logic [31:0] off_dur;
    logic [47:0] stamp;
    logic [7:0]  cnt;
    logic [7:0]  stb;
  } burst_t;

  function automatic logic [4:0] map_layout(input logic [7:0] g, input logic [7:0] v);
    logic [15:0] k;
    logic [4:0]  r;
    k = {g, v};
    case (k)
      {8'd1, 8'd1}, {8'd80, 8'd1}: r = 5'd0;
      {8'd1, 8'd2}, {8'd2, 8'd1}, {8'd10, 8'd2}, {8'd3, 8'd2}, {8'd4, 8'd1}: r = 5'd1;
      {8'd2, 8'd2}:  r = 5'd2;
      {8'd12, 8'd1}: r = 5'd3;
      {8'd20, 8'd1}, {8'd21, 8'd1}, {8'd22, 8'd1}, {8'd30, 8'd1}, {8'd30, 8'd5},
      {8'd32, 8'd1}, {8'd40, 8'd1}: r = 5'd4;
      {8'd22, 8'd2}, {8'd30, 8'd2}, {8'd32, 8'd2}: r = 5'd5;
      {8'd30, 8'd4}: r = 5'd6;
      {8'd32, 8'd3}, {8'd32, 8'd7}: r = 5'd7;
      {8'd50, 8'd3}: r = 5'd8;
      {8'd60, 8'd0}, {8'd60, 8'd1}, {8'd60, 8'd2}, {8'd60, 8'd3},
      {8'd60, 8'd4}: r = MAP_NODATA;
      default: r = MAP_UNKNOWN;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] pfx_bytes(input logic [2:0] mode);
    logic [2:0] r;
    case (mode)
      3'd1, 3'd4: r = 3'd1;
      3'd2, 3'd5: r = 3'd2;
      3'd3, 3'd6: r = 3'd4;
      default:    r = 3'd0;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] rec_len(input logic [3:0] lay);
    logic [3:0] r;
    case (lay)
      4'd0: r = 4'd0;
      4'd2: r = 4'd7;
      4'd3: r = 4'd11;
      4'd4: r = 4'd5;
      4'd5: r = 4'd3;
      4'd6: r = 4'd2;
      4'd7: r = 4'd11;
      4'd8: r = 4'd6;
      default: r = 4'd1;
    endcase
    return r;
  endfunction

  function automatic logic has_flag(input logic [3:0] lay);
    return (lay != 4'd0) && (lay != 4'd6) && (lay != 4'd8);
  endfunction

  function automatic logic [2:0] val_len(input logic [3:0] lay);
    logic [2:0] r;
    case (lay)
      4'd4, 4'd7: r = 3'd4;
      4'd5, 4'd6: r = 3'd2;
      default:    r = 3'd0;
    endcase
    return r;
  endfunction

endpackage

FILE: sv/dnpr_if.sv
// Valid/ready channel interfaces for the parser's input items and results.
// Depends on dnpr_pkg.
interface dnpr_in_if;
  logic          valid;
  logic          ready;
  dnpr_pkg::in_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface dnpr_out_if;
  logic           valid;
  logic           ready;
  dnpr_pkg::out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: sv/dnp3_object_record_parser.sv
// DNP3 object record parser top level: decode state and per-byte field
// assembly. Depends on dnpr_pkg, dnpr_if and dnpr_emit.
//
//   channel  dir  payload                         handshake
//   in_i     in   kind, header fields, data_byte  valid/ready
//   out_o    out  status, layout, record fields   valid/ready
//
// Each input transaction is decoded in the cycle it is accepted and its
// results go into a burst register that gives one result per cycle while
// the output is ready. An item yielding at most one result sustains one item
// per cycle while the output is ready; an item with more results, such as a
// packed-bit byte with nine results, stalls the input until its last is taken.
// Reset clears all decode state; no results are pending after reset.
// A stalled output holds the input once the burst register is occupied.
module dnp3_object_record_parser (
  input  logic       clk_i,
  input  logic       rst_ni,
  dnpr_in_if.sink    in_i,
  dnpr_out_if.source out_o
);
  import dnpr_pkg::*;

  logic        busy_q, busy_d;
  logic [3:0]  lay_q, lay_d;
  logic [2:0]  mode_q, mode_d;
  logic [31:0] left_q, left_d;
  logic [31:0] nidx_q, nidx_d;
  logic [3:0]  bpos_q, bpos_d;
  logic        pdone_q, pdone_d;
  logic [31:0] pacc_q, pacc_d;
  logic [7:0]  flag_q, flag_d;
  logic [31:0] vacc_q, vacc_d;
  logic [31:0] oacc_q, oacc_d;
  logic [47:0] sacc_q, sacc_d;
  logic [7:0]  cnt_q, cnt_d;
  logic [7:0]  stb_q, stb_d;

  burst_t      burst;
  logic        produce;
  logic        take;
  logic        accept;
  logic [4:0]  map;
  logic [2:0]  pl;
  logic [3:0]  f;
  logic [3:0]  g;
  logic [3:0]  h;
  logic [3:0]  k;
  logic [7:0]  d;

  assign in_i.ready = take;
  assign accept     = in_i.valid && take;
  assign d          = in_i.data.data_byte;

  always_comb begin
    busy_d = busy_q;  lay_d = lay_q;   mode_d = mode_q; left_d = left_q;
    nidx_d = nidx_q;  bpos_d = bpos_q; pdone_d = pdone_q; pacc_d = pacc_q;
    flag_d = flag_q;  vacc_d = vacc_q; oacc_d = oacc_q; sacc_d = sacc_q;
    cnt_d = cnt_q;    stb_d = stb_q;
    burst = '0;
    burst.tail_status = ST_DONE;
    produce = 1'b0;
    map = map_layout(in_i.data.group, in_i.data.variation);
    pl = pfx_bytes(mode_q);
    f = '0; g = '0; h = '0; k = '0;
    case (in_i.data.kind)
      KIND_HDR: begin
        busy_d = 1'b0; bpos_d = '0; pacc_d = '0; flag_d = '0; vacc_d = '0;
        oacc_d = '0; sacc_d = '0; cnt_d = '0; stb_d = '0; pdone_d = 1'b0;
        produce = 1'b1;
        burst.tail = 1'b1;
        if (map == MAP_UNKNOWN) begin
          lay_d = LAY_BITS;
          burst.tail_status = ST_UNKNOWN;
        end else if (map == MAP_NODATA) begin
          lay_d = LAY_BITS;
        end else begin
          lay_d   = map[3:0];
          mode_d  = in_i.data.pfx_sel;
          nidx_d  = in_i.data.start_index;
          left_d  = in_i.data.object_count;
          pdone_d = pfx_bytes(in_i.data.pfx_sel) == 3'd0;
          burst.layout = map[3:0];
          if (in_i.data.object_count == 32'd0) begin
            burst.tail = 1'b1;
          end else begin
            busy_d  = 1'b1;
            produce = 1'b0;
          end
        end
      end
      KIND_DATA: begin
        if (busy_q && lay_q == LAY_BITS) begin
          if (!pdone_q) begin
            pacc_d[8*bpos_q[1:0] +: 8] = d;
            if ({1'b0, bpos_q} + 5'd1 >= {2'd0, pl}) begin
              pdone_d = 1'b1;
              bpos_d  = '0;
            end else begin
              bpos_d = bpos_q + 4'd1;
            end
          end else begin
            k = (left_q > 32'd8) ? 4'd8 : left_q[3:0];
            nidx_d = nidx_q + {28'd0, k};
            left_d = left_q - {28'd0, k};
            produce          = 1'b1;
            burst.is_bits    = 1'b1;
            burst.n_obj      = k;
            burst.layout     = LAY_BITS;
            burst.use_prefix = (mode_q >= 3'd1) && (mode_q <= 3'd3);
            burst.point_base = nidx_q;
            burst.prefix     = pacc_q;
            burst.flags      = d;
            if (left_d == 32'd0) begin
              busy_d     = 1'b0;
              burst.tail = 1'b1;
            end
          end
        end else if (busy_q) begin
          if (bpos_q < {1'b0, pl}) begin
            pacc_d[8*bpos_q[1:0] +: 8] = d;
          end else begin
            f = bpos_q - {1'b0, pl};
            if (lay_q == LAY_CROB) begin
              if (f == 4'd0)      flag_d = d;
              else if (f == 4'd1) cnt_d = d;
              else if (f < 4'd6)  vacc_d[8*(f - 4'd2) +: 8] = d;
              else if (f < 4'd10) oacc_d[8*(f - 4'd6) +: 8] = d;
              else                stb_d = d;
            end else if (has_flag(lay_q) && f == 4'd0) begin
              flag_d = d;
            end else begin
              g = f - {3'd0, has_flag(lay_q)};
              if (g < {1'b0, val_len(lay_q)}) begin
                vacc_d[8*g[1:0] +: 8] = d;
              end else begin
                h = g - {1'b0, val_len(lay_q)};
                if (h < 4'd6) sacc_d[8*h[2:0] +: 8] = d;
              end
            end
          end
          bpos_d = bpos_q + 4'd1;
          if ({1'b0, bpos_q} + 5'd1 >= {2'd0, pl} + {1'b0, rec_len(lay_q)}) begin
            produce          = 1'b1;
            burst.n_obj      = 4'd1;
            burst.layout     = lay_q;
            burst.use_prefix = (mode_q >= 3'd1) && (mode_q <= 3'd3);
            burst.point_base = nidx_q;
            burst.prefix     = pacc_d;
            burst.flags      = flag_d;
            burst.value      = vacc_d;
            burst.off_dur    = oacc_d;
            burst.stamp      = sacc_d;
            burst.cnt        = cnt_d;
            burst.stb        = stb_d;
            nidx_d = nidx_q + 32'd1;
            left_d = left_q - 32'd1;
            bpos_d = '0; pacc_d = '0; flag_d = '0; vacc_d = '0;
            oacc_d = '0; sacc_d = '0; cnt_d = '0; stb_d = '0;
            if (left_d == 32'd0) begin
              busy_d     = 1'b0;
              burst.tail = 1'b1;
            end
          end
        end
      end
      KIND_END: begin
        if (busy_q) begin
          busy_d = 1'b0;
          bpos_d = '0; pacc_d = '0; flag_d = '0; vacc_d = '0;
          oacc_d = '0; sacc_d = '0; cnt_d = '0; stb_d = '0;
          produce = 1'b1;
          burst.tail = 1'b1;
          burst.tail_status = ST_MALFORMED;
          burst.layout = lay_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; lay_q <= '0; mode_q <= '0; left_q <= '0; nidx_q <= '0;
      bpos_q <= '0; pdone_q <= 1'b0; pacc_q <= '0; flag_q <= '0; vacc_q <= '0;
      oacc_q <= '0; sacc_q <= '0; cnt_q <= '0; stb_q <= '0;
    end else if (accept) begin
      busy_q <= busy_d; lay_q <= lay_d; mode_q <= mode_d; left_q <= left_d;
      nidx_q <= nidx_d; bpos_q <= bpos_d; pdone_q <= pdone_d; pacc_q <= pacc_d;
      flag_q <= flag_d; vacc_q <= vacc_d; oacc_q <= oacc_d; sacc_q <= sacc_d;
      cnt_q <= cnt_d; stb_q <= stb_d;
    end
  end

  dnpr_emit u_emit (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (accept && produce),
    .burst_i (burst),
    .take_o  (take),
    .out_o   (out_o)
  );

endmodule

FILE: sv/dnpr_emit.sv
// Result register: holds one burst descriptor and plays out its results,
// one per cycle while out_o.ready is high. Depends on dnpr_pkg and dnpr_if.
module dnpr_emit (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  dnpr_pkg::burst_t burst_i,
  output logic             take_o,
  dnpr_out_if.source       out_o
);
  import dnpr_pkg::*;

  logic       valid_q;
  logic [3:0] idx_q;
  burst_t     b_q;
  logic       on_obj;
  logic       final_res;

  assign on_obj    = idx_q < b_q.n_obj;
  assign final_res = b_q.tail ? (idx_q == b_q.n_obj) : (idx_q == b_q.n_obj - 4'd1);
  assign take_o    = !valid_q || (out_o.ready && final_res);
  assign out_o.valid = valid_q;

  always_comb begin
    out_o.data = '0;
    out_o.data.last = final_res;
    if (on_obj) begin
      out_o.data.status        = ST_OBJ;
      out_o.data.layout        = b_q.layout;
      out_o.data.point_index   = b_q.use_prefix ? b_q.prefix
                                                : b_q.point_base + {28'd0, idx_q};
      out_o.data.prefix_value  = b_q.prefix;
      out_o.data.flags         = b_q.is_bits ? {7'd0, b_q.flags[idx_q[2:0]]} : b_q.flags;
      out_o.data.value         = b_q.value;
      out_o.data.off_dur       = b_q.off_dur;
      out_o.data.timestamp     = b_q.stamp;
      out_o.data.control_count = b_q.cnt;
      out_o.data.status_byte   = b_q.stb;
    end else begin
      out_o.data.status = b_q.tail_status;
      out_o.data.layout = b_q.layout;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else if (load_i) begin
      valid_q <= 1'b1;
      idx_q   <= '0;
    end else if (valid_q && out_o.ready) begin
      if (final_res) begin
        valid_q <= 1'b0;
      end else begin
        idx_q <= idx_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      b_q <= burst_i;
    end
  end

endmodule
